### sv/skrsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrsa_pkg: shared types and constants of the small-key RSA character cipher
// Beat payloads, configuration register indexes and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package skrsa_pkg;

  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int SGN_W     = WORD_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_P_PRIME = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_Q_PRIME = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] FIRST_EXP = WORD_W'(3);
  localparam logic [WORD_W-1:0] EXP_STEP  = WORD_W'(2);
  localparam logic [WORD_W-1:0] BYTE_MASK = WORD_W'(8'hFF);

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] in_value;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_value;
    logic              key_fault;
  } rsp_t;

endpackage

### sv/small_key_rsa_char_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_key_rsa_char_cipher: textbook RSA over two configured small primes
// Derives n, e and d from the primes on the first beat after reset or a register write,
// then answers each beat with a modular exponentiation.
// ----------------------------------------------------------------------------
// Write the two primes through the configuration port, then send beats. The
// first beat after reset or after any register write triggers key derivation:
// both primes are trial-divided, phi = (p-1)(q-1) is formed, e is the first odd
// value from 3 upward coprime to phi (stopping once it reaches phi), and d is
// found by extended Euclid. This is done once, and every trial division and
// every Euclid step is a pass of the shared divider. After that, an encrypt or
// decrypt beat costs one reduction of the input plus, per exponent bit up to the
// top set bit, one squaring and, where the bit is set, one extra multiply, each
// followed by a 64-step division. The single restoring divider produces one
// quotient bit per cycle. One beat is worked on at a time; a finished result
// sits in the output register so the next beat is taken once the sequencer is
// idle again. With invalid keys every beat answers zero with key_fault set.
module small_key_rsa_char_cipher #(
  parameter int PRIME_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [skrsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [skrsa_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  skrsa_pkg::req_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output skrsa_pkg::rsp_t                      out_data_o
);

  localparam int W  = skrsa_pkg::WORD_W;
  localparam int PW = skrsa_pkg::PROD_W;
  localparam int SW = skrsa_pkg::SGN_W;
  localparam int KW = PRIME_BITS + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_PR_START, S_PR_LOOP, S_PR_WAIT, S_PHI_MUL, S_PHI_SET,
    S_E_LOOP, S_GCD_LOOP, S_GCD_WAIT, S_INV_INIT, S_INV_LOOP, S_INV_WAIT,
    S_INV_MUL, S_INV_UPD, S_INV_FIN, S_N_MUL, S_N_SET, S_FAIL, S_CHECK,
    S_POW_RED, S_POW_RWAIT, S_POW_LOOP, S_POW_AM, S_POW_AWAIT, S_POW_SQ,
    S_POW_SD, S_POW_SWAIT, S_DONE
  } state_e;

  state_e state_q;

  // Configuration and derived keys.
  logic [PRIME_BITS-1:0] p_q, q_q;
  logic [W-1:0]          modulus_q, pub_exp_q, priv_exp_q;
  logic                  keys_ready_q, key_invalid_q;

  // Captured beat.
  logic                  req_type_q;
  logic [W-1:0]          value_q;

  // Derivation working registers.
  logic                  prime_sel_q;
  logic [KW-1:0]         k_q;
  logic [W-1:0]          phi_q, e_q, ga_q, gb_q, r0_q, r1_q, qt_q;
  logic signed [SW-1:0]  s0_q, s1_q;

  // Exponentiation working registers.
  logic [W-1:0]          acc_q, base_q, ex_q;

  // Shared multiplier, product registered every cycle.
  logic [W-1:0]          mul_a, mul_b;
  logic [PW-1:0]         prod_q;

  // Shared restoring divider, one quotient bit per cycle.
  logic [skrsa_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [PW-1:0]         div_quo_q;
  logic [W-1:0]          div_rem_q, div_den_q;
  logic [W:0]            div_t;
  logic                  div_ge;
  logic [W:0]            div_sub;

  // Output register.
  logic                  out_valid_q;
  skrsa_pkg::rsp_t       out_q, res_q;

  // Combinational helpers.
  logic [PRIME_BITS-1:0] cand;
  logic [2*KW-1:0]       k_sq;
  logic [SW-1:0]         s1_mag;
  logic signed [SW-1:0]  s_new, d_pre;
  logic [SW-1:0]         d_fix;
  logic                  div_done;

  assign cand     = prime_sel_q ? q_q : p_q;
  assign k_sq     = k_q * k_q;
  assign div_t    = {div_rem_q, div_quo_q[PW-1]};
  assign div_ge   = div_t >= {1'b0, div_den_q};
  assign div_sub  = div_t - {1'b0, div_den_q};
  assign div_done = (div_cnt_q == '0);
  assign s1_mag   = s1_q[SW-1] ? SW'(-s1_q) : SW'(s1_q);

  // Bezout update: s0 - qt * s1, with the magnitude product re-signed.
  assign s_new = s1_q[SW-1] ? s0_q + $signed(prod_q[SW-1:0])
                            : s0_q - $signed(prod_q[SW-1:0]);
  // Final coefficient folded into 0 .. phi-1.
  assign d_pre = s0_q[SW-1] ? s0_q + $signed({2'b00, phi_q}) : s0_q;
  assign d_fix = (d_pre == $signed({2'b00, phi_q})) ? '0 : SW'(d_pre);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_PHI_MUL: begin
        mul_a = W'(p_q) - W'(1);
        mul_b = W'(q_q) - W'(1);
      end
      S_INV_MUL: begin
        mul_a = qt_q;
        mul_b = s1_mag[W-1:0];
      end
      S_N_MUL: begin
        mul_a = W'(p_q);
        mul_b = W'(q_q);
      end
      S_POW_LOOP: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      S_POW_SQ: begin
        mul_a = base_q;
        mul_b = base_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      p_q           <= '0;
      q_q           <= '0;
      modulus_q     <= '0;
      pub_exp_q     <= '0;
      priv_exp_q    <= '0;
      keys_ready_q  <= 1'b0;
      key_invalid_q <= 1'b0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;

      if (!div_done) begin
        div_rem_q <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
        div_quo_q <= {div_quo_q[PW-2:0], div_ge};
        div_cnt_q <= div_cnt_q - 1'b1;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == skrsa_pkg::CFG_P_PRIME) begin
          p_q          <= cfg_data_i[PRIME_BITS-1:0];
          keys_ready_q <= 1'b0;
        end else if (cfg_idx_i == skrsa_pkg::CFG_Q_PRIME) begin
          q_q          <= cfg_data_i[PRIME_BITS-1:0];
          keys_ready_q <= 1'b0;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_type_q  <= in_data_i.req_type;
            value_q     <= in_data_i.in_value;
            prime_sel_q <= 1'b0;
            state_q     <= keys_ready_q ? S_CHECK : S_PR_START;
          end
        end
        S_PR_START: begin
          k_q     <= KW'(2);
          state_q <= (cand < PRIME_BITS'(2)) ? S_FAIL : S_PR_LOOP;
        end
        S_PR_LOOP: begin
          if (k_sq > {{(2*KW-PRIME_BITS){1'b0}}, cand}) begin
            if (!prime_sel_q) begin
              prime_sel_q <= 1'b1;
              state_q     <= S_PR_START;
            end else begin
              state_q <= (p_q == q_q) ? S_FAIL : S_PHI_MUL;
            end
          end else begin
            div_quo_q <= PW'(cand);
            div_den_q <= W'(k_q);
            div_rem_q <= '0;
            div_cnt_q <= skrsa_pkg::DIV_CNT_W'(skrsa_pkg::DIV_STEPS);
            state_q   <= S_PR_WAIT;
          end
        end
        S_PR_WAIT: begin
          if (div_done) begin
            if (div_rem_q == '0) begin
              state_q <= S_FAIL;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_PR_LOOP;
            end
          end
        end
        S_PHI_MUL: begin
          state_q <= S_PHI_SET;
        end
        S_PHI_SET: begin
          phi_q   <= prod_q[W-1:0];
          e_q     <= skrsa_pkg::FIRST_EXP;
          state_q <= S_E_LOOP;
        end
        S_E_LOOP: begin
          if (e_q >= phi_q) begin
            state_q <= S_INV_INIT;
          end else begin
            ga_q    <= e_q;
            gb_q    <= phi_q;
            state_q <= S_GCD_LOOP;
          end
        end
        S_GCD_LOOP: begin
          if (gb_q == '0) begin
            if (ga_q == W'(1)) begin
              state_q <= S_INV_INIT;
            end else begin
              e_q     <= e_q + skrsa_pkg::EXP_STEP;
              state_q <= S_E_LOOP;
            end
          end else begin
            div_quo_q <= PW'(ga_q);
            div_den_q <= gb_q;
            div_rem_q <= '0;
            div_cnt_q <= skrsa_pkg::DIV_CNT_W'(skrsa_pkg::DIV_STEPS);
            state_q   <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: begin
          if (div_done) begin
            ga_q    <= gb_q;
            gb_q    <= div_rem_q;
            state_q <= S_GCD_LOOP;
          end
        end
        S_INV_INIT: begin
          r0_q    <= e_q;
          r1_q    <= phi_q;
          s0_q    <= SW'(1);
          s1_q    <= '0;
          state_q <= S_INV_LOOP;
        end
        S_INV_LOOP: begin
          if (r1_q == '0) begin
            state_q <= S_INV_FIN;
          end else begin
            div_quo_q <= PW'(r0_q);
            div_den_q <= r1_q;
            div_rem_q <= '0;
            div_cnt_q <= skrsa_pkg::DIV_CNT_W'(skrsa_pkg::DIV_STEPS);
            state_q   <= S_INV_WAIT;
          end
        end
        S_INV_WAIT: begin
          if (div_done) begin
            qt_q    <= div_quo_q[W-1:0];
            r0_q    <= r1_q;
            r1_q    <= div_rem_q;
            state_q <= S_INV_MUL;
          end
        end
        S_INV_MUL: begin
          state_q <= S_INV_UPD;
        end
        S_INV_UPD: begin
          s0_q    <= s1_q;
          s1_q    <= s_new;
          state_q <= S_INV_LOOP;
        end
        S_INV_FIN: begin
          state_q <= (r0_q == W'(1)) ? S_N_MUL : S_FAIL;
        end
        S_N_MUL: begin
          state_q <= S_N_SET;
        end
        S_N_SET: begin
          keys_ready_q  <= 1'b1;
          key_invalid_q <= 1'b0;
          modulus_q     <= prod_q[W-1:0];
          pub_exp_q     <= e_q;
          priv_exp_q    <= d_fix[W-1:0];
          state_q       <= S_CHECK;
        end
        S_FAIL: begin
          keys_ready_q  <= 1'b1;
          key_invalid_q <= 1'b1;
          modulus_q     <= '0;
          pub_exp_q     <= '0;
          priv_exp_q    <= '0;
          state_q       <= S_CHECK;
        end
        S_CHECK: begin
          if (key_invalid_q || modulus_q == '0) begin
            res_q.result_value <= '0;
            res_q.key_fault    <= 1'b1;
            state_q            <= S_DONE;
          end else begin
            state_q <= S_POW_RED;
          end
        end
        S_POW_RED: begin
          div_quo_q <= PW'(value_q);
          div_den_q <= modulus_q;
          div_rem_q <= '0;
          div_cnt_q <= skrsa_pkg::DIV_CNT_W'(skrsa_pkg::DIV_STEPS);
          state_q   <= S_POW_RWAIT;
        end
        S_POW_RWAIT: begin
          if (div_done) begin
            base_q  <= div_rem_q;
            acc_q   <= W'(1);
            ex_q    <= (req_type_q == skrsa_pkg::REQ_DECRYPT) ? priv_exp_q : pub_exp_q;
            state_q <= S_POW_LOOP;
          end
        end
        S_POW_LOOP: begin
          if (ex_q == '0) begin
            res_q.result_value <= (req_type_q == skrsa_pkg::REQ_DECRYPT)
                                  ? (acc_q & skrsa_pkg::BYTE_MASK) : acc_q;
            res_q.key_fault    <= 1'b0;
            state_q            <= S_DONE;
          end else begin
            state_q <= ex_q[0] ? S_POW_AM : S_POW_SQ;
          end
        end
        S_POW_AM: begin
          div_quo_q <= prod_q;
          div_den_q <= modulus_q;
          div_rem_q <= '0;
          div_cnt_q <= skrsa_pkg::DIV_CNT_W'(skrsa_pkg::DIV_STEPS);
          state_q   <= S_POW_AWAIT;
        end
        S_POW_AWAIT: begin
          if (div_done) begin
            acc_q   <= div_rem_q;
            state_q <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          state_q <= S_POW_SD;
        end
        S_POW_SD: begin
          div_quo_q <= prod_q;
          div_den_q <= modulus_q;
          div_rem_q <= '0;
          div_cnt_q <= skrsa_pkg::DIV_CNT_W'(skrsa_pkg::DIV_STEPS);
          state_q   <= S_POW_SWAIT;
        end
        S_POW_SWAIT: begin
          if (div_done) begin
            base_q  <= div_rem_q;
            ex_q    <= ex_q >> 1;
            state_q <= S_POW_LOOP;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A faulted answer always carries a zero value.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_fault |-> out_data_o.result_value == '0)
    else $error("fault beat with non-zero value");

  // The divider is never started with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cnt_q == skrsa_pkg::DIV_CNT_W'(skrsa_pkg::DIV_STEPS) |-> div_den_q != '0)
    else $error("division by zero started");

  // A beat is only taken while the divider is quiet.
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> div_cnt_q == '0)
    else $error("beat accepted during a division");

  // Valid keys always come with a usable modulus.
  a_keys_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keys_ready_q && !key_invalid_q && state_q == S_CHECK |-> modulus_q != '0)
    else $error("valid keys with zero modulus");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the small-key RSA character cipher
// Programs several prime pairs (valid, equal, composite, zero and the largest
// 16-bit primes), sends encrypt and decrypt beats with random gaps while the
// result side stalls on its own pattern, and checks every result beat against
// a predictor that derives the keys and exponentiates the way the block does.
// ----------------------------------------------------------------------------

// Predictor and store of expected result beats.
class rsa_scoreboard;
  logic [skrsa_pkg::CFG_W-1:0]  p_fac, q_fac;
  logic [skrsa_pkg::WORD_W-1:0] n_mod, e_pub, d_priv;
  bit                           derived, bad_keys;
  skrsa_pkg::rsp_t              expected_q[$];
  int                           fails;

  function void clear_state();
    p_fac = '0; q_fac = '0;
    n_mod = '0; e_pub = '0; d_priv = '0;
    derived = 0; bad_keys = 0;
  endfunction

  // Any register write forces a fresh key derivation on the next beat.
  function void write_reg(logic [skrsa_pkg::CFG_IDX_W-1:0] idx,
                          logic [skrsa_pkg::CFG_W-1:0] val);
    if (idx == skrsa_pkg::CFG_P_PRIME) begin
      p_fac = val; derived = 0;
    end else if (idx == skrsa_pkg::CFG_Q_PRIME) begin
      q_fac = val; derived = 0;
    end
  endfunction

  function bit prime_test(longint unsigned v);
    longint unsigned k;
    if (v < 2) return 0;
    for (k = 2; k * k <= v; k++)
      if (v % k == 0) return 0;
    return 1;
  endfunction

  function longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b; a = b; b = r;
    end
    return a;
  endfunction

  function longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                    longint unsigned m);
    longint unsigned acc;
    acc = 1;
    base = base % m;
    while (ex > 0) begin
      if (ex[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function void derive();
    longint unsigned p, q, phi, e;
    longint r0, r1, s0, s1, qt, t, mm;
    p = p_fac; q = q_fac;
    derived = 1;
    n_mod = '0; e_pub = '0; d_priv = '0;
    bad_keys = 1;
    if (!prime_test(p) || !prime_test(q) || p == q) return;
    phi = (p - 1) * (q - 1);
    e = skrsa_pkg::FIRST_EXP;
    while (e < phi && gcd_of(e, phi) != 1) e += skrsa_pkg::EXP_STEP;
    // Extended Euclid on signed 64-bit values.
    r0 = e; r1 = phi; s0 = 1; s1 = 0;
    while (r1 != 0) begin
      qt = r0 / r1;
      t = r0 - qt * r1; r0 = r1; r1 = t;
      t = s0 - qt * s1; s0 = s1; s1 = t;
    end
    if (r0 != 1) return;
    mm = phi;
    n_mod = skrsa_pkg::WORD_W'(p * q);
    e_pub = skrsa_pkg::WORD_W'(e);
    d_priv = skrsa_pkg::WORD_W'(((s0 % mm) + mm) % mm);
    bad_keys = 0;
  endfunction

  function void note_request(skrsa_pkg::req_t r);
    skrsa_pkg::rsp_t exp_rsp;
    if (!derived) derive();
    if (bad_keys || n_mod == 0) begin
      exp_rsp.result_value = '0;
      exp_rsp.key_fault = 1'b1;
    end else if (r.req_type == skrsa_pkg::REQ_ENCRYPT) begin
      exp_rsp.result_value = skrsa_pkg::WORD_W'(pow_mod(r.in_value, e_pub, n_mod));
      exp_rsp.key_fault = 1'b0;
    end else begin
      exp_rsp.result_value = skrsa_pkg::WORD_W'(pow_mod(r.in_value, d_priv, n_mod))
                             & skrsa_pkg::BYTE_MASK;
      exp_rsp.key_fault = 1'b0;
    end
    expected_q.push_back(exp_rsp);
  endfunction

  function void check_result(skrsa_pkg::rsp_t got);
    skrsa_pkg::rsp_t want;
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected: value %0h fault %0b",
             got.result_value, got.key_fault);
      fails++;
      return;
    end
    want = expected_q.pop_front();
    if (got.result_value !== want.result_value) begin
      $error("result_value: expected %0h, actual %0h", want.result_value,
             got.result_value);
      fails++;
    end
    if (got.key_fault !== want.key_fault) begin
      $error("key_fault: expected %0b, actual %0b", want.key_fault, got.key_fault);
      fails++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;

  // The limit leaves ample headroom for the long derivations of the largest primes.
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [skrsa_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [skrsa_pkg::CFG_W-1:0]     cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  skrsa_pkg::req_t                 in_data;
  logic                            out_valid;
  logic                            out_ready;
  skrsa_pkg::rsp_t                 out_data;

  rsa_scoreboard sb;
  int unsigned   cycle_count;
  int unsigned   burst_left;
  int unsigned   stall_mode;
  int unsigned   stall_timer;

  small_key_rsa_char_cipher #(.PRIME_BITS(16)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Free-running 20 ns clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side. A beat is taken at an edge where valid and ready were both
  // high; the ready pattern then moves through modes of its own, from always
  // ready to heavily stalled, so that stalls land on every phase of the work.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(16, 200);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_timer[3:0] < 4'd10);
    endcase
  end

  // Write one register at the next edge. Only called while the block is idle.
  task automatic write_cfg(logic [skrsa_pkg::CFG_IDX_W-1:0] idx,
                           logic [skrsa_pkg::CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Present one beat and hold it until accepted. Bursts of back-to-back
  // beats alternate with random gaps; valid is only lowered for a gap, so it
  // never gets two assignments in one time step.
  task automatic send_req(logic rtype, logic [skrsa_pkg::WORD_W-1:0] val);
    skrsa_pkg::req_t r;
    r.req_type = rtype;
    r.in_value = val;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Wait until every expected beat has come back, then allow some settling.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Small random prime, found by stepping upwards from a random start in the range given.
  function automatic logic [skrsa_pkg::CFG_W-1:0] pick_prime(int unsigned lo,
                                                              int unsigned hi);
    int unsigned v;
    v = $urandom_range(lo, hi);
    while (!sb.prime_test(v)) v++;
    return skrsa_pkg::CFG_W'(v);
  endfunction

  // Extremes of the input field and both operations.
  task automatic directed_beats();
    logic [skrsa_pkg::WORD_W-1:0] n;
    send_req(skrsa_pkg::REQ_ENCRYPT, '0);
    send_req(skrsa_pkg::REQ_DECRYPT, '0);
    send_req(skrsa_pkg::REQ_ENCRYPT, 32'hFFFF_FFFF);
    send_req(skrsa_pkg::REQ_DECRYPT, 32'hFFFF_FFFF);
    n = sb.n_mod;
    if (n != 0) begin
      // Inputs at and above the modulus are reduced before exponentiation.
      send_req(skrsa_pkg::REQ_ENCRYPT, n - 1);
      send_req(skrsa_pkg::REQ_ENCRYPT, n);
      send_req(skrsa_pkg::REQ_DECRYPT, n + 1);
      send_req(skrsa_pkg::REQ_ENCRYPT, 32'd65);
    end
  endtask

  // Random beats: encrypt-then-decrypt round trips of a random byte,
  // with raw encrypts and decrypts of arbitrary numbers mixed in.
  task automatic random_beats(int count);
    logic [skrsa_pkg::WORD_W-1:0] ch, ct;
    for (int i = 0; i < count; i++) begin
      ch = $urandom_range(0, 255);
      case ($urandom_range(0, 4))
        0, 1: begin
          send_req(skrsa_pkg::REQ_ENCRYPT, ch);
          if (sb.n_mod != 0) begin
            ct = skrsa_pkg::WORD_W'(sb.pow_mod(ch, sb.e_pub, sb.n_mod));
            send_req(skrsa_pkg::REQ_DECRYPT, ct);
          end else begin
            send_req(skrsa_pkg::REQ_DECRYPT, $urandom);
          end
        end
        2: send_req(1'($urandom_range(0, 1)),
                    (sb.n_mod != 0) ? $urandom_range(0, sb.n_mod - 1) : $urandom);
        default: send_req(1'($urandom_range(0, 1)), $urandom);
      endcase
    end
  endtask

  task automatic key_phase(logic [skrsa_pkg::CFG_W-1:0] p,
                           logic [skrsa_pkg::CFG_W-1:0] q, int count);
    drain();
    write_cfg(skrsa_pkg::CFG_P_PRIME, p);
    write_cfg(skrsa_pkg::CFG_Q_PRIME, q);
    // The first beat triggers derivation; the predictor derives on the same
    // beat, so the modulus seen by the stimulus is ready once a beat is sent.
    send_req(skrsa_pkg::REQ_ENCRYPT, 32'd72);
    directed_beats();
    random_beats(count);
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    cycle_count = 0;
    burst_left  = 0;
    stall_mode  = 0;
    stall_timer = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset both factors are zero, so every beat faults.
    directed_beats();

    key_phase(16'd61, 16'd53, 6);
    // Pause the sender until everything has come back, then go on.
    drain();
    random_beats(6);

    // Equal factors, a composite factor, and an all-ones register value.
    key_phase(16'd13, 16'd13, 2);
    key_phase(16'd15, 16'd17, 2);
    key_phase(16'hFFFF, 16'd0, 2);
    // Smallest usable pair: phi is 2, so the exponent search stops at once.
    key_phase(16'd2, 16'd3, 4);

    // Writes to indexes outside the register list change nothing.
    drain();
    write_cfg(skrsa_pkg::CFG_IDX_W'(2), 16'hA5A5);
    write_cfg(skrsa_pkg::CFG_IDX_W'(3), 16'h5A5A);
    random_beats(4);

    // Largest 16-bit primes: full-width modulus and exponents, so few beats.
    key_phase(16'd65521, 16'd65519, 3);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 2)
        key_phase(16'd7, 16'd7, 2);
      else
        key_phase(pick_prime(2, 400), pick_prime(2, 400), 6);
    end

    drain();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
